>>> hdl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and saturating fixed-point helpers for the
// Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int DATA_W = 32;           // signed fixed-point word
  localparam int FRAC_W = 28;           // fractional bits of the word
  localparam int PROD_W = 2 * DATA_W;   // full-precision product
  localparam int ITER_W = 16;           // iteration limit and count field
  localparam int CNT_W  = ITER_W + 1;   // count must reach limit + 1
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [PROD_W:0] Q_MAX_WIDE =
    {{(PROD_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}};

  // Fixed-point constant num * 2^sh, saturated to the largest word
  function automatic q_t fconst(int unsigned num, int sh);
    logic [PROD_W:0] v;
    v = (PROD_W+1)'(num) << (FRAC_W + sh);
    if (v > Q_MAX_WIDE) return Q_MAX;
    return q_t'(v[DATA_W-1:0]);
  endfunction

  localparam q_t Q_ONE   = fconst(1, 0);
  localparam q_t Q_THREE = fconst(3, 0);
  localparam q_t Q_FOUR  = fconst(4, 0);
  localparam q_t Q_3_32  = fconst(3, -5);
  localparam q_t Q_1_16  = fconst(1, -4);

  // Register index taken from the APB byte address
  typedef enum logic {
    REG_MAX_ITER = 1'b0,
    REG_SHORTCUT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_MUL,
    ST_SC_SUM,
    ST_SC_PREP,
    ST_SC_CARD,
    ST_SC_DEC,
    ST_IT_MUL,
    ST_IT_STEP
  } st_t;

  typedef enum logic [1:0] {
    MUL_SC,
    MUL_CARD,
    MUL_Z
  } mul_op_t;

  typedef struct packed {
    logic    load_c;
    logic    z_clear;
    logic    mul_en;
    mul_op_t mul_op;
    logic    sc_sum;
    logic    sc_prep;
    logic    z_step;
    logic    out_load;
    logic    out_inside;
  } cmd_t;

  typedef struct packed {
    logic sc_hit;
    logic it_go;
    logic it_over;
  } stat_t;

  function automatic q_t sat_add(q_t a, q_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? Q_MIN : Q_MAX;
    return q_t'(s[DATA_W-1:0]);
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? Q_MIN : Q_MAX;
    return q_t'(s[DATA_W-1:0]);
  endfunction

  // Eight times a, clamped like three saturating doublings
  function automatic q_t sat_x8(q_t a);
    logic signed [DATA_W+2:0] w;
    w = (DATA_W+3)'(a) <<< 3;
    if (w > (DATA_W+3)'(Q_MAX)) return Q_MAX;
    if (w < (DATA_W+3)'(Q_MIN)) return Q_MIN;
    return q_t'(w[DATA_W-1:0]);
  endfunction

  // Floor of product / 2^FRAC_W, clamped to the word range
  function automatic q_t prod_to_q(prod_t p);
    prod_t sh;
    sh = p >>> FRAC_W;
    if (sh > prod_t'(Q_MAX)) return Q_MAX;
    if (sh < prod_t'(Q_MIN)) return Q_MIN;
    return q_t'(sh[DATA_W-1:0]);
  endfunction

endpackage

>>> hdl/mbe_regs.sv
// ----------------------------------------------------------------------------
// mbe_regs
// APB register file: iteration limit and shortcut enable.
// ----------------------------------------------------------------------------
module mbe_regs import mbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [ITER_W-1:0] max_iter,
  output logic              shortcut_en
);

  logic [ITER_W-1:0] max_iter_r;
  logic              shortcut_en_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r    <= ITER_W'(255);
      shortcut_en_r <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_ITER: max_iter_r    <= pwdata[ITER_W-1:0];
        REG_SHORTCUT: shortcut_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_ITER: prdata = CFG_DW'(max_iter_r);
      REG_SHORTCUT: prdata = CFG_DW'(shortcut_en_r);
      default:      prdata = '0;
    endcase
  end

  assign max_iter    = max_iter_r;
  assign shortcut_en = shortcut_en_r;

endmodule

>>> hdl/mbe_dpath.sv
// ----------------------------------------------------------------------------
// mbe_dpath
// Datapath: point and orbit registers, three registered multipliers,
// saturating adders, escape counter and result register.
// ----------------------------------------------------------------------------
module mbe_dpath import mbe_pkg::*; (
  input  logic              clk,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] in_c_real,
  input  logic [DATA_W-1:0] in_c_imag,
  input  logic [ITER_W-1:0] max_iter,
  output stat_t             stat,
  output logic [ITER_W-1:0] out_escape_count,
  output logic              out_inside_set
);

  q_t                c_re_r, c_im_r;
  q_t                zr_r, zi_r;
  q_t                a_r, k_r;
  logic              a_lt_one_r, bulb_r;
  prod_t             m0_r, m1_r, m2_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ITER_W-1:0] out_cnt_r;
  logic              out_inside_r;

  q_t   x1, a0, b0, a1, b1, a2, b2;
  q_t   q0, q1, q2;
  q_t   a_nxt, mag;
  logic [CNT_W-1:0] lim;

  assign x1 = sat_add(c_re_r, Q_ONE);

  // Operand select for the three multipliers
  always_comb begin
    a1 = zi_r;
    b1 = zi_r;
    a2 = zr_r;
    b2 = zi_r;
    case (cmd.mul_op)
      MUL_SC: begin
        a0 = c_re_r;
        b0 = c_re_r;
        a1 = c_im_r;
        b1 = c_im_r;
        a2 = x1;
        b2 = x1;
      end
      MUL_CARD: begin
        a0 = k_r;
        b0 = a_r;
      end
      default: begin
        a0 = zr_r;
        b0 = zr_r;
      end
    endcase
  end

  assign q0    = prod_to_q(m0_r);
  assign q1    = prod_to_q(m1_r);
  assign q2    = prod_to_q(m2_r);
  assign a_nxt = sat_add(q0, q1);
  assign mag   = sat_add(q0, q1);
  assign lim   = CNT_W'(max_iter);

  assign stat.sc_hit  = bulb_r || (a_lt_one_r && (sat_add(q0, c_re_r) < Q_3_32));
  assign stat.it_go   = (mag <= Q_FOUR) && (cnt_r <= lim);
  assign stat.it_over = cnt_r > lim;

  always_ff @(posedge clk) begin
    if (cmd.load_c) begin
      c_re_r <= q_t'(in_c_real);
      c_im_r <= q_t'(in_c_imag);
    end
    if (cmd.mul_en) begin
      m0_r <= PROD_W'(a0) * PROD_W'(b0);
      m1_r <= PROD_W'(a1) * PROD_W'(b1);
      m2_r <= PROD_W'(a2) * PROD_W'(b2);
    end
    if (cmd.sc_sum) begin
      a_r        <= a_nxt;
      a_lt_one_r <= a_nxt < Q_ONE;
      bulb_r     <= sat_add(q2, q1) < Q_1_16;
    end
    if (cmd.sc_prep) begin
      k_r <= sat_sub(sat_x8(a_r), Q_THREE);
    end
    if (cmd.z_clear) begin
      zr_r  <= '0;
      zi_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.z_step) begin
      zr_r  <= sat_add(sat_sub(q0, q1), c_re_r);
      zi_r  <= sat_add(sat_add(q2, q2), c_im_r);
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_cnt_r    <= cmd.out_inside ? '0 : cnt_r[ITER_W-1:0];
      out_inside_r <= cmd.out_inside;
    end
  end

  assign out_escape_count = out_cnt_r;
  assign out_inside_set   = out_inside_r;

endmodule

>>> hdl/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Controller: sequences the shortcut tests and the orbit iterations and
// owns both handshakes.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  logic  shortcut_en,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t  state_r, state_nxt;
  logic inside_r, inside_nxt;
  logic done_r, done_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt  = state_r;
    inside_nxt = inside_r;
    done_nxt   = done_r;
    case (state_r)
      ST_IDLE: begin
        if (done_r) begin
          if (out_free) done_nxt = 1'b0;
        end else if (accept) begin
          state_nxt = shortcut_en ? ST_SC_MUL : ST_IT_MUL;
        end
      end
      ST_SC_MUL:  state_nxt = ST_SC_SUM;
      ST_SC_SUM:  state_nxt = ST_SC_PREP;
      ST_SC_PREP: state_nxt = ST_SC_CARD;
      ST_SC_CARD: state_nxt = ST_SC_DEC;
      ST_SC_DEC: begin
        if (stat.sc_hit) begin
          inside_nxt = 1'b1;
          done_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_IT_MUL;
        end
      end
      ST_IT_MUL: state_nxt = ST_IT_STEP;
      ST_IT_STEP: begin
        if (stat.it_go) begin
          state_nxt = ST_IT_MUL;
        end else begin
          inside_nxt = stat.it_over;
          done_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_Z;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (done_r) begin
          if (out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_inside = inside_r;
            out_valid_nxt  = 1'b1;
          end
        end else begin
          in_ready    = 1'b1;
          cmd.load_c  = accept;
          cmd.z_clear = accept;
        end
      end
      ST_SC_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SC;
      end
      ST_SC_SUM:  cmd.sc_sum  = 1'b1;
      ST_SC_PREP: cmd.sc_prep = 1'b1;
      ST_SC_CARD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_CARD;
      end
      ST_IT_MUL:  cmd.mul_en = 1'b1;
      ST_IT_STEP: cmd.z_step = stat.it_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inside_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inside_r    <= inside_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time classifier for one complex point c in signed Q4.28, with
// optional main-cardioid and period-2 bulb interior tests.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | beat contents
//   ---------+------------------------+--------------------------------------
//   in       | in_valid / in_ready    | in_c_real, in_c_imag
//   out      | out_valid / out_ready  | out_escape_count, out_inside_set
//   cfg      | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// Steps: an orbit step is a multiply state, then an add and escape-check
// state. When enabled, the shortcut tests run first in the states SC_MUL,
// SC_SUM, SC_PREP, SC_CARD and SC_DEC; a hit ends the point there. The
// result register is loaded once the controller is back in idle.
// Reset: rst_n is synchronous; it clears the controller and output valid and
// loads max_iter = 255, shortcut_enable = 1.
// Stalls: a finished result waits in the output register while the next
// point is accepted; a second finished result holds until the first is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_c_real,
  input  logic [DATA_W-1:0] in_c_imag,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ITER_W-1:0] out_escape_count,
  output logic              out_inside_set,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [ITER_W-1:0] max_iter;
  logic              shortcut_en;
  cmd_t              cmd;
  stat_t             stat;

  // Registers: max_iter at byte 0, shortcut_enable at byte 4
  mbe_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_iter    (max_iter),
    .shortcut_en (shortcut_en)
  );

  // Sequence the tests and iterations; drive the handshakes
  mbe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shortcut_en (shortcut_en),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Hold the point and orbit; compute products, sums and the count
  mbe_dpath u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .in_c_real        (in_c_real),
    .in_c_imag        (in_c_imag),
    .max_iter         (max_iter),
    .stat             (stat),
    .out_escape_count (out_escape_count),
    .out_inside_set   (out_inside_set)
  );

  // Work on one point at a time: after an input beat the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a point is in flight");

  // An inside result always carries a zero count
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_set |-> out_escape_count == '0)
    else $error("inside result with nonzero count");

  // An escaped point reports a count from 1 to the limit
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_set |-> out_escape_count != '0 && out_escape_count <= max_iter)
    else $error("escape count out of range");

endmodule
